// File: design/best_fit_extent_allocator_defines.svh
// assertion macros for the best-fit extent allocator
// used by the modules that carry concurrent checks; no dependencies
`ifndef BEST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFEA_ASSERT(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |-> (post)) \
		else $error("bfea assertion failed");

// next-cycle implication
`define BFEA_ASSERT_NEXT(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |=> (post)) \
		else $error("bfea assertion failed");

`endif

// File: design/bfea_pkg.sv
// types and constants of the best-fit extent allocator
// no dependencies
package bfea_pkg;

	localparam int SEC_W = 24;
	localparam int KEY_W = 16;
	localparam int CMD_W = 2;
	localparam int STS_W = 3;
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_DEL    = 2'd1,
		CMD_RESIZE = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK          = 3'd0,
		STS_NOT_MOUNTED = 3'd1,
		STS_NOT_FOUND   = 3'd2,
		STS_KEY_EXISTS  = 3'd3,
		STS_TABLE_FULL  = 3'd4,
		STS_NO_SPACE    = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOUNTED = 1'd0,
		REG_TOTAL   = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_NEXT,
		S_FIT,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SEC_W-1:0] start;
		logic [SEC_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic             mounted;
		logic [SEC_W-1:0] total;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [SEC_W-1:0] start;
		logic [SEC_W-1:0] used;
		logic [CNT_W-1:0] count;
	} resp_t;

endpackage

// File: design/bfea_req_if.sv
// request and response channel interfaces of the extent allocator
// depends on bfea_pkg
interface bfea_req_if;
	logic                        valid;
	logic                        ready;
	logic [bfea_pkg::CMD_W-1:0]  command;
	logic [bfea_pkg::KEY_W-1:0]  file_key;
	logic [bfea_pkg::SEC_W-1:0]  sector_count;
	modport source (output valid, command, file_key, sector_count, input ready);
	modport sink (input valid, command, file_key, sector_count, output ready);
endinterface

interface bfea_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bfea_pkg::STS_W-1:0]  status;
	logic [bfea_pkg::SEC_W-1:0]  first_sector;
	logic [bfea_pkg::SEC_W-1:0]  sectors_allocated;
	logic [bfea_pkg::CNT_W-1:0]  entry_count;
	modport source (output valid, status, first_sector, sectors_allocated, entry_count,
		input ready);
	modport sink (input valid, status, first_sector, sectors_allocated, entry_count,
		output ready);
endinterface

// File: design/bfea_mem.sv
// extent table memory: one write port, one registered read port
// depends on bfea_pkg
module bfea_mem #(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IW-1:0]     waddr,
	input  bfea_pkg::entry_t  wdata,
	input  logic [IW-1:0]     raddr,
	output bfea_pkg::entry_t  rdata
);

	bfea_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/bfea_ctrl.sv
// command sequencer and shared scan datapath of the extent allocator
// depends on bfea_pkg, bfea_mem and the assertion macro header
`include "best_fit_extent_allocator_defines.svh"

module bfea_ctrl #(
	parameter int MAX_EXTENTS = 32,
	parameter int IW          = 5,
	parameter int CW          = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bfea_pkg::cfg_t              cfg,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [bfea_pkg::CMD_W-1:0]  req_command,
	input  logic [bfea_pkg::KEY_W-1:0]  req_key,
	input  logic [bfea_pkg::SEC_W-1:0]  req_count,
	output logic                        resp_valid,
	input  logic                        resp_ready,
	output bfea_pkg::resp_t             resp
);

	localparam int SW = bfea_pkg::SEC_W;
	localparam int W1 = SW + 1;
	localparam int W2 = SW + 2;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_EXTENTS);

	bfea_pkg::state_t  state_q, state_d;
	bfea_pkg::cmd_t    cmd_q, cmd_in;
	bfea_pkg::status_t status_q;
	logic [bfea_pkg::KEY_W-1:0] key_q;
	logic [SW-1:0] cnt_q, alloc_q, fstart_q, flen_q, next_q, prev_q, grp_min_q, start_q;
	logic [CW-1:0] n_q, ptr_q, end_q;
	logic [IW-1:0] fidx_q, idx_s1;
	logic          found_q, other_q, have_prev_q, bfound_q, skip_en_q, grp_any_q, v_s1;
	logic [W1-1:0] cur_q, best_q, bsize_q, grp_end_q;

	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	bfea_pkg::entry_t mem_wdata, rd;

	bfea_mem #(.DEPTH(MAX_EXTENTS), .IW(IW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ptr_q[IW-1:0]),
		.rdata (rd)
	);

	assign cmd_in = bfea_pkg::cmd_t'(req_command);

	logic          pass_done, full, add_over, shrink, grow_over, fits_inplace;
	logic          gap_ok, fin_ok, found_fin, add_fits, skip_hit;
	logic [SW-1:0] grow;
	logic [W1-1:0] end_ext, avail, gap, fin_gap, need, where, add_sum, grow_sum, e_rd;
	logic [W2-1:0] pos_end;

	always_comb begin
		pass_done    = (ptr_q >= end_q) && !v_s1;
		full         = n_q >= MAX_C;
		need         = {1'b0, cnt_q};
		add_sum      = {1'b0, alloc_q} + need;
		add_over     = add_sum > {1'b0, cfg.total};
		shrink       = cnt_q <= flen_q;
		grow         = cnt_q - flen_q;
		grow_sum     = {1'b0, alloc_q} + {1'b0, grow};
		grow_over    = grow_sum > {1'b0, cfg.total};
		end_ext      = {1'b0, fstart_q} + {1'b0, flen_q};
		avail        = ({1'b0, next_q} >= end_ext) ? ({1'b0, next_q} - end_ext) : '0;
		fits_inplace = avail >= {1'b0, grow};
		gap          = {1'b0, grp_min_q} - cur_q;
		gap_ok       = ({1'b0, grp_min_q} > cur_q) && (gap >= need)
			&& (!bfound_q || gap < bsize_q);
		fin_gap      = {1'b0, cfg.total} - cur_q;
		fin_ok       = (cur_q < {1'b0, cfg.total}) && (fin_gap >= need)
			&& (!bfound_q || fin_gap < bsize_q);
		found_fin    = bfound_q || fin_ok;
		where        = (bfound_q && !fin_ok) ? best_q : cur_q;
		pos_end      = {1'b0, where} + {2'b0, cnt_q};
		add_fits     = pos_end <= {2'b0, cfg.total};
		skip_hit     = idx_s1 == fidx_q;
		e_rd         = {1'b0, rd.start} + {1'b0, rd.len};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfea_pkg::S_IDLE: begin
				if (req_valid) begin
					if (!cfg.mounted || cmd_in == bfea_pkg::CMD_RSVD
							|| (cmd_in == bfea_pkg::CMD_ADD && full)) begin
						state_d = bfea_pkg::S_RESP;
					end else begin
						state_d = bfea_pkg::S_LOOKUP;
					end
				end
			end
			bfea_pkg::S_LOOKUP: begin
				if (pass_done) begin
					unique case (cmd_q)
						bfea_pkg::CMD_ADD: state_d = (found_q || add_over) ?
							bfea_pkg::S_RESP : bfea_pkg::S_FIT;
						bfea_pkg::CMD_DEL: state_d = found_q ?
							bfea_pkg::S_SHIFT : bfea_pkg::S_RESP;
						bfea_pkg::CMD_RESIZE: state_d = (!found_q || shrink || grow_over) ?
							bfea_pkg::S_RESP : bfea_pkg::S_NEXT;
						default: state_d = bfea_pkg::S_RESP;
					endcase
				end
			end
			bfea_pkg::S_NEXT: begin
				if (pass_done) begin
					state_d = fits_inplace ? bfea_pkg::S_RESP : bfea_pkg::S_FIT;
				end
			end
			bfea_pkg::S_FIT: begin
				if (pass_done && !grp_any_q) begin
					state_d = bfea_pkg::S_RESP;
				end
			end
			bfea_pkg::S_SHIFT: begin
				if (pass_done) begin
					state_d = bfea_pkg::S_RESP;
				end
			end
			bfea_pkg::S_RESP: begin
				if (resp_ready) begin
					state_d = bfea_pkg::S_IDLE;
				end
			end
			default: state_d = bfea_pkg::S_IDLE;
		endcase
	end

	// outputs and table writes
	always_comb begin
		req_ready    = state_q == bfea_pkg::S_IDLE;
		resp_valid   = state_q == bfea_pkg::S_RESP;
		resp.status  = status_q;
		resp.start   = start_q;
		resp.used    = alloc_q;
		resp.count   = bfea_pkg::CNT_W'(n_q);
		mem_we       = 1'b0;
		mem_waddr    = fidx_q;
		mem_wdata    = '{key: key_q, start: fstart_q, len: cnt_q};
		unique case (state_q)
			bfea_pkg::S_SHIFT: begin
				mem_we    = v_s1;
				mem_waddr = idx_s1 - IW'(1);
				mem_wdata = rd;
			end
			bfea_pkg::S_LOOKUP: begin
				mem_we = pass_done && cmd_q == bfea_pkg::CMD_RESIZE && found_q && shrink;
			end
			bfea_pkg::S_NEXT: begin
				mem_we = pass_done && fits_inplace;
			end
			bfea_pkg::S_FIT: begin
				mem_wdata.start = where[SW-1:0];
				if (cmd_q == bfea_pkg::CMD_ADD) begin
					mem_waddr = n_q[IW-1:0];
					mem_we    = pass_done && !grp_any_q && add_fits;
				end else begin
					mem_we    = pass_done && !grp_any_q && found_fin;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfea_pkg::S_IDLE;
			n_q         <= '0;
			alloc_q     <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			cmd_q       <= bfea_pkg::CMD_ADD;
			status_q    <= bfea_pkg::STS_OK;
			key_q       <= '0;
			cnt_q       <= '0;
			start_q     <= '0;
			found_q     <= 1'b0;
			fidx_q      <= '0;
			fstart_q    <= '0;
			flen_q      <= '0;
			next_q      <= '0;
			other_q     <= 1'b0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			cur_q       <= '0;
			best_q      <= '0;
			bsize_q     <= '0;
			bfound_q    <= 1'b0;
			skip_en_q   <= 1'b0;
			grp_any_q   <= 1'b0;
			grp_min_q   <= '0;
			grp_end_q   <= '0;
		end else begin
			state_q <= state_d;
			// scan pipeline: address issue, data in the following cycle
			if (ptr_q < end_q) begin
				ptr_q  <= ptr_q + CW'(1);
				v_s1   <= 1'b1;
				idx_s1 <= ptr_q[IW-1:0];
			end else begin
				v_s1 <= 1'b0;
			end
			unique case (state_q)
				bfea_pkg::S_IDLE: begin
					if (req_valid) begin
						cmd_q    <= cmd_in;
						key_q    <= req_key;
						cnt_q    <= req_count;
						start_q  <= '0;
						found_q  <= 1'b0;
						ptr_q    <= '0;
						end_q    <= '0;
						if (!cfg.mounted) begin
							status_q <= bfea_pkg::STS_NOT_MOUNTED;
						end else if (cmd_in == bfea_pkg::CMD_RSVD) begin
							status_q <= bfea_pkg::STS_NOT_FOUND;
						end else if (cmd_in == bfea_pkg::CMD_ADD && full) begin
							status_q <= bfea_pkg::STS_TABLE_FULL;
						end else begin
							status_q <= bfea_pkg::STS_OK;
							end_q    <= n_q;
						end
					end
				end
				bfea_pkg::S_LOOKUP: begin
					if (v_s1 && !found_q && rd.key == key_q) begin
						found_q  <= 1'b1;
						fidx_q   <= idx_s1;
						fstart_q <= rd.start;
						flen_q   <= rd.len;
					end
					if (pass_done) begin
						ptr_q       <= '0;
						end_q       <= n_q;
						next_q      <= cfg.total;
						other_q     <= 1'b0;
						have_prev_q <= 1'b0;
						cur_q       <= '0;
						bfound_q    <= 1'b0;
						grp_any_q   <= 1'b0;
						skip_en_q   <= cmd_q != bfea_pkg::CMD_ADD;
						unique case (cmd_q)
							bfea_pkg::CMD_ADD: begin
								if (found_q) begin
									status_q <= bfea_pkg::STS_KEY_EXISTS;
								end else if (add_over) begin
									status_q <= bfea_pkg::STS_NO_SPACE;
								end
							end
							bfea_pkg::CMD_DEL: begin
								if (!found_q) begin
									status_q <= bfea_pkg::STS_NOT_FOUND;
								end else begin
									alloc_q <= alloc_q - flen_q;
									ptr_q   <= CW'(fidx_q) + CW'(1);
								end
							end
							bfea_pkg::CMD_RESIZE: begin
								if (!found_q) begin
									status_q <= bfea_pkg::STS_NOT_FOUND;
								end else if (shrink) begin
									alloc_q <= alloc_q - (flen_q - cnt_q);
									start_q <= fstart_q;
								end else if (grow_over) begin
									status_q <= bfea_pkg::STS_NO_SPACE;
								end
							end
							default: status_q <= bfea_pkg::STS_NOT_FOUND;
						endcase
					end
				end
				bfea_pkg::S_NEXT: begin
					if (v_s1 && !skip_hit && {1'b0, rd.start} >= end_ext
							&& (!other_q || rd.start < next_q)) begin
						next_q  <= rd.start;
						other_q <= 1'b1;
					end
					if (pass_done) begin
						ptr_q <= '0;
						end_q <= n_q;
						if (fits_inplace) begin
							alloc_q <= grow_sum[SW-1:0];
							start_q <= fstart_q;
						end
					end
				end
				bfea_pkg::S_FIT: begin
					// pick the lowest start above the last one, with its farthest end
					if (v_s1 && !(skip_en_q && skip_hit)
							&& (!have_prev_q || rd.start > prev_q)) begin
						if (!grp_any_q || rd.start < grp_min_q) begin
							grp_any_q <= 1'b1;
							grp_min_q <= rd.start;
							grp_end_q <= e_rd;
						end else if (rd.start == grp_min_q && e_rd > grp_end_q) begin
							grp_end_q <= e_rd;
						end
					end
					if (pass_done) begin
						if (grp_any_q) begin
							if (gap_ok) begin
								bfound_q <= 1'b1;
								best_q   <= cur_q;
								bsize_q  <= gap;
							end
							if (grp_end_q > cur_q) begin
								cur_q <= grp_end_q;
							end
							prev_q      <= grp_min_q;
							have_prev_q <= 1'b1;
							grp_any_q   <= 1'b0;
							ptr_q       <= '0;
							end_q       <= n_q;
						end else if (cmd_q == bfea_pkg::CMD_ADD) begin
							if (add_fits) begin
								n_q     <= n_q + CW'(1);
								alloc_q <= add_sum[SW-1:0];
								start_q <= where[SW-1:0];
							end else begin
								status_q <= bfea_pkg::STS_NO_SPACE;
							end
						end else begin
							if (found_fin) begin
								alloc_q <= grow_sum[SW-1:0];
								start_q <= where[SW-1:0];
							end else begin
								status_q <= bfea_pkg::STS_NO_SPACE;
							end
						end
					end
				end
				bfea_pkg::S_SHIFT: begin
					if (pass_done) begin
						n_q <= n_q - CW'(1);
					end
				end
				bfea_pkg::S_RESP: begin
					ptr_q <= '0;
					end_q <= '0;
				end
				default: ptr_q <= '0;
			endcase
		end
	end

	`BFEA_ASSERT(a_count_bound, clk, arst_n, 1'b1, n_q <= MAX_C)
	`BFEA_ASSERT(a_shift_not_head, clk, arst_n, state_q == bfea_pkg::S_SHIFT && v_s1,
		idx_s1 != '0)
	`BFEA_ASSERT_NEXT(a_busy_blocks_req, clk, arst_n,
		state_q != bfea_pkg::S_IDLE && state_d != bfea_pkg::S_IDLE, !req_ready)
	`BFEA_ASSERT(a_count_change_src, clk, arst_n, n_q != $past(n_q),
		$past(state_q) == bfea_pkg::S_FIT || $past(state_q) == bfea_pkg::S_SHIFT)

endmodule

// File: design/best_fit_extent_allocator.sv
// best-fit contiguous extent allocator
// commands arrive on req (add, delete, resize of one extent by file key) and
// each gives exactly one response on rsp: status, start sector, used sectors
// and the number of extents in the table. Mount flag and data-area size are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce it. One
// command is worked at a time; req.ready is low while it runs. Every step
// walks the table through one read port, one entry per cycle. Lookup is one
// pass, delete adds one shift pass, an in-place grow one more, and a
// best-fit placement needs one pass per distinct start sector plus one;
// errors found before the lookup skip all passes and respond directly.
// Responses sit in an output register, so a stalled receiver holds only
// that register; a new command can be taken meanwhile and waits to respond.
// Reset empties the table, clears used sectors and unmounts the volume.
// depends on bfea_pkg, bfea_req_if, bfea_ctrl, bfea_mem
module best_fit_extent_allocator #(
	parameter int MAX_EXTENTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bfea_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfea_pkg::SEC_W-1:0]      cfg_data,
	bfea_req_if.sink                        req,
	bfea_rsp_if.source                      rsp
);

	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);

	bfea_pkg::cfg_t  cfg_q;
	bfea_pkg::resp_t ctrl_resp, out_q;
	logic            ctrl_resp_valid, ctrl_resp_ready, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (bfea_pkg::reg_idx_t'(cfg_index))
				bfea_pkg::REG_MOUNTED: cfg_q.mounted <= cfg_data[0];
				bfea_pkg::REG_TOTAL:   cfg_q.total <= cfg_data;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	bfea_ctrl #(.MAX_EXTENTS(MAX_EXTENTS), .IW(IW), .CW(CW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_command (req.command),
		.req_key     (req.file_key),
		.req_count   (req.sector_count),
		.resp_valid  (ctrl_resp_valid),
		.resp_ready  (ctrl_resp_ready),
		.resp        (ctrl_resp)
	);

	assign ctrl_resp_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_resp_valid && ctrl_resp_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_resp_valid && ctrl_resp_ready) begin
			out_q <= ctrl_resp;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_q.status;
	assign rsp.first_sector      = out_q.start;
	assign rsp.sectors_allocated = out_q.used;
	assign rsp.entry_count       = out_q.count;

endmodule
